// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must never hold at a clock edge
`define CCPF_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ccpf check failed");

// ante implies cons in the same cycle
`define CCPF_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ccpf check failed");

// ante implies cons in the following cycle
`define CCPF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ccpf check failed");

`endif

// ===== sv/ccpf_pkg.sv =====
// ----------------------------------------------------------------------------
// ccpf_pkg
// Shared constants, types and the shade lookup for the char cell framebuffer.
// ----------------------------------------------------------------------------
package ccpf_pkg;

    localparam int MAX_WIDTH   = 32;
    localparam int MAX_HEIGHT  = 32;
    localparam int STORE_CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int STORE_AW    = $clog2(STORE_CELLS);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int DIM_W       = 6;   // width of frame_width / frame_height

    // input commands
    localparam logic [1:0] CMD_PLOT  = 2'd0;
    localparam logic [1:0] CMD_EMIT  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // back-end operations
    localparam logic [1:0] OP_PLOT  = 2'd0;
    localparam logic [1:0] OP_EMIT  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FRAME_WIDTH = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_FULL_CODE   = 2'd2;

    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 6'd32;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 6'd32;
    localparam logic [7:0]       FULL_CODE_RST    = 8'd219;

    localparam logic [7:0] FULL_LEVEL   = 8'd255;
    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] SPACE_CODE   = 8'h20;
    localparam int         RAMP_STEPS   = 9;

    localparam logic [7:0] SHADE_RAMP [0:7] = '{
        8'h2E, 8'h3A, 8'h2D, 8'h3D, 8'h2B, 8'h2A, 8'h23, 8'h40
    };

    typedef struct packed {
        logic [1:0]          op;
        logic [STORE_AW-1:0] addr;    // cell index for plot, row base for emit
        logic [7:0]          value;
        logic [DIM_W-1:0]    width;   // active width for emit
    } q_entry_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

    // level = min(v*9/255, 8): count thresholds 255*k crossed by 9*v
    function automatic logic [7:0] shade_code(input logic [7:0] v,
                                              input logic [7:0] full_code);
        logic [11:0] prod;
        logic [3:0]  level;
        logic [7:0]  code;
        prod  = 12'(v) * 12'(RAMP_STEPS);
        level = 4'd0;
        for (int k = 1; k <= 8; k++)
        begin
            if (prod >= 12'(int'(FULL_LEVEL) * k))
                level = 4'(k);
        end
        if (v == 8'd0)
            code = SPACE_CODE;
        else if (level == 4'd8)
            code = full_code;
        else
            code = SHADE_RAMP[level[2:0]];
        return code;
    endfunction

endpackage

// ===== sv/ccpf_front.sv =====
// ----------------------------------------------------------------------------
// ccpf_front
// Classifies accepted items, range-checks coordinates and forms cell addresses.
// ----------------------------------------------------------------------------
module ccpf_front (
    input  logic                       accept,
    input  logic [1:0]                 command,
    input  logic signed [7:0]          x_coord,
    input  logic signed [7:0]          y_coord,
    input  logic [7:0]                 point_intensity,
    input  logic                       intensity_sel,
    input  logic [ccpf_pkg::DIM_W-1:0] act_w,
    input  logic [ccpf_pkg::DIM_W-1:0] act_h,
    output logic                       push,
    output ccpf_pkg::q_entry_t         entry
);
    import ccpf_pkg::*;

    logic                    x_ok;
    logic                    y_ok;
    logic [ROW_W+DIM_W-1:0]  row_prod;
    logic [STORE_AW-1:0]     row_base;

    assign x_ok = !x_coord[7] && (x_coord[6:0] < 7'(act_w));
    assign y_ok = !y_coord[7] && (y_coord[6:0] < 7'(act_h));

    assign row_prod = (ROW_W+DIM_W)'(y_coord[ROW_W-1:0]) * (ROW_W+DIM_W)'(act_w);
    assign row_base = row_prod[STORE_AW-1:0];

    always_comb
    begin
        entry.width = act_w;
        entry.value = intensity_sel ? point_intensity : FULL_LEVEL;
        entry.addr  = row_base;
        entry.op    = OP_CLEAR;
        push        = 1'b0;
        unique case (command)
            CMD_PLOT:
            begin
                entry.op   = OP_PLOT;
                entry.addr = row_base + STORE_AW'(x_coord[COL_W-1:0]);
                push       = accept && x_ok && y_ok;
            end
            CMD_EMIT:
            begin
                entry.op = OP_EMIT;
                push     = accept && y_ok;
            end
            CMD_CLEAR:
            begin
                entry.op = OP_CLEAR;
                push     = accept;
            end
            default:
            begin
                push = 1'b0;   // unused command: nothing to do
            end
        endcase
    end

endmodule

// ===== sv/ccpf_queue.sv =====
// ----------------------------------------------------------------------------
// ccpf_queue
// Two-entry queue decoupling the classifier from the store sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccpf_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ccpf_pkg::q_entry_t push_entry,
    input  logic               pop,
    output logic               head_valid,
    output ccpf_pkg::q_entry_t head_entry,
    output logic               full
);
    import ccpf_pkg::*;

    q_entry_t   ent_reg [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    assign head_valid = (count_reg != 2'd0);
    assign head_entry = ent_reg[rd_ptr_reg];
    assign full       = (count_reg == 2'd2);
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `CCPF_ASSERT_NEVER(a_q_overflow, push && full)

endmodule

// ===== sv/ccpf_back.sv =====
// ----------------------------------------------------------------------------
// ccpf_back
// Store sequencer: plots, row emission through an output queue, clear sweeps.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ccpf_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  ccpf_pkg::q_entry_t     q_entry,
    output logic                   q_pop,
    input  logic [7:0]             full_code,
    output logic [7:0]             char_code,
    output logic                   row_last,
    output logic                   out_valid,
    input  logic                   out_stall,
    output ccpf_pkg::back_status_t status
);
    import ccpf_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EMIT  = 2'd1;
    localparam logic [1:0] ST_CLEAR = 2'd2;

    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = OQ_AW + 1;

    logic [7:0]          mem [0:STORE_CELLS-1];

    logic [1:0]          state_reg, state_next;
    logic [STORE_AW-1:0] base_reg, base_next;
    logic [DIM_W-1:0]    width_reg, width_next;
    logic [DIM_W-1:0]    col_reg, col_next;
    logic [STORE_AW-1:0] clr_reg, clr_next;
    logic                init_reg, init_next;

    logic                wr_en;
    logic [STORE_AW-1:0] wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [STORE_AW-1:0] rd_addr;
    logic                nl_issue;
    logic                credit_ok;

    logic [7:0]          rd_data_reg;
    logic                rd_pend_reg;
    logic                rd_nl_reg;

    logic [7:0]          oq_code_reg [0:OQ_DEPTH-1];
    logic                oq_last_reg [0:OQ_DEPTH-1];
    logic [OQ_AW-1:0]    oq_wr_reg, oq_rd_reg;
    logic [OQ_CW-1:0]    oq_count_reg, oq_count_next;
    logic                oq_push, oq_pop;
    logic [7:0]          oq_code_in;

    assign status.init_busy = init_reg;

    // at most 3 items queued or in flight when a read issues, so a push always fits
    assign credit_ok = ((OQ_CW+1)'(oq_count_reg) + (OQ_CW+1)'(rd_pend_reg))
                       < (OQ_CW+1)'(OQ_DEPTH - 1);
    assign rd_addr   = base_reg + STORE_AW'(col_reg);

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        width_next = width_reg;
        col_next   = col_reg;
        clr_next   = clr_reg;
        init_next  = init_reg;
        wr_en      = 1'b0;
        wr_addr    = clr_reg;
        wr_data    = 8'd0;
        rd_en      = 1'b0;
        nl_issue   = 1'b0;
        q_pop      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    unique case (q_entry.op)
                        OP_PLOT:
                        begin
                            wr_en   = 1'b1;
                            wr_addr = q_entry.addr;
                            wr_data = q_entry.value;
                        end
                        OP_EMIT:
                        begin
                            base_next  = q_entry.addr;
                            width_next = q_entry.width;
                            col_next   = '0;
                            state_next = ST_EMIT;
                        end
                        OP_CLEAR:
                        begin
                            clr_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_EMIT:
            begin
                if (credit_ok)
                begin
                    if (col_reg < width_reg)
                    begin
                        rd_en    = 1'b1;
                        col_next = col_reg + DIM_W'(1);
                    end
                    else
                    begin
                        nl_issue   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                clr_next = clr_reg + STORE_AW'(1);
                if (clr_reg == STORE_AW'(STORE_CELLS - 1))
                begin
                    state_next = ST_IDLE;
                    init_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        base_reg  <= base_next;
        width_reg <= width_next;
        col_reg   <= col_next;
    end

    // the reset sweep starts at cell 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            init_reg    <= 1'b1;
            clr_reg     <= '0;
            rd_pend_reg <= 1'b0;
            rd_nl_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            clr_reg     <= clr_next;
            rd_pend_reg <= rd_en || nl_issue;
            rd_nl_reg   <= nl_issue;
        end
    end

    // output queue
    assign oq_push    = rd_pend_reg;
    assign oq_pop     = out_valid && !out_stall;
    assign oq_code_in = rd_nl_reg ? NEWLINE_CODE : shade_code(rd_data_reg, full_code);
    assign out_valid  = (oq_count_reg != '0);
    assign char_code  = oq_code_reg[oq_rd_reg];
    assign row_last   = oq_last_reg[oq_rd_reg];
    assign oq_count_next = oq_count_reg + OQ_CW'(oq_push) - OQ_CW'(oq_pop);

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_code_reg[oq_wr_reg] <= oq_code_in;
            oq_last_reg[oq_wr_reg] <= rd_nl_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= '0;
            oq_rd_reg    <= '0;
            oq_count_reg <= '0;
        end
        else
        begin
            oq_wr_reg    <= oq_wr_reg + OQ_AW'(oq_push);
            oq_rd_reg    <= oq_rd_reg + OQ_AW'(oq_pop);
            oq_count_reg <= oq_count_next;
        end
    end

    `CCPF_ASSERT_NEVER(a_oq_overflow, oq_push && !oq_pop && (oq_count_reg == OQ_CW'(OQ_DEPTH)))
    `CCPF_ASSERT_IMPLY(a_no_write_in_emit, state_reg == ST_EMIT, !wr_en)
    `CCPF_ASSERT_NEXT(a_read_returns, rd_en, rd_pend_reg && !rd_nl_reg)

endmodule

// ===== sv/char_cell_point_framebuffer_top.sv =====
// ----------------------------------------------------------------------------
// char_cell_point_framebuffer_top
// 32x32 8-bit intensity store with point plotting and ASCII shade row output.
// ----------------------------------------------------------------------------
// Flow: an accepted item is registered in the queue, then popped by the idle back end;
//   a plot is written to the store as it is popped; a row's chars pass the emit state,
//   the registered store read and the output queue. Plots go 1 item per cycle while the
//   back end is idle; an emit (single store read port) or a clear (write port) holds it.
// Reset: config registers go to 32/32/219 and the store is swept to zero, during which
//   in_stall stays high; config writes are taken throughout.
module char_cell_point_framebuffer_top (
    input  logic              clk,
    input  logic              rst_n,
    // command items
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        command,
    input  logic signed [7:0] x_coord,
    input  logic signed [7:0] y_coord,
    input  logic [7:0]        point_intensity,
    input  logic              intensity_sel,
    // character items
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        char_code,
    output logic              row_last,
    // configuration writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data
);
    import ccpf_pkg::*;

    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic [7:0]       full_code_reg;
    logic [DIM_W-1:0] act_w;
    logic [DIM_W-1:0] act_h;

    logic             accept;
    logic             f_push;
    q_entry_t         f_entry;
    logic             q_valid;
    q_entry_t         q_head;
    logic             q_full;
    logic             q_pop;
    back_status_t     b_status;

    // registers are always writable; the user only writes while idle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            full_code_reg    <= FULL_CODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data[DIM_W-1:0];
                CFG_FULL_CODE:    full_code_reg    <= cfg_data;
                default:          ;   // index beyond the register list: dropped
            endcase
        end
    end

    // width/height beyond the store size clamp to the store size
    assign act_w = (frame_width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH)
                                                         : frame_width_reg;
    assign act_h = (frame_height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                           : frame_height_reg;

    // no item enters while the queue is full or the reset sweep is running
    assign in_stall = q_full || b_status.init_busy;
    assign accept   = in_valid && !in_stall;

    // front: range checks and address forming; dropped items never reach the queue
    ccpf_front u_front (
        .accept          (accept),
        .command         (command),
        .x_coord         (x_coord),
        .y_coord         (y_coord),
        .point_intensity (point_intensity),
        .intensity_sel   (intensity_sel),
        .act_w           (act_w),
        .act_h           (act_h),
        .push            (f_push),
        .entry           (f_entry)
    );

    ccpf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (f_push),
        .push_entry (f_entry),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_entry (q_head),
        .full       (q_full)
    );

    // back: owns the store, sequences emits and clears, drives the output queue
    ccpf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_entry   (q_head),
        .q_pop     (q_pop),
        .full_code (full_code_reg),
        .char_code (char_code),
        .row_last  (row_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (b_status)
    );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the char cell point framebuffer: plots, row emits,
// clears and unused codes go in through a queue-fed driver, the characters
// that come out are checked against a cell store mirrored inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import ccpf_pkg::*;

    // command code with no function, and the register index past the list
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [1:0] CFG_NONE   = 2'd3;

    // shade glyphs for levels 0..7: . : - = + * # @
    localparam logic [7:0] GLYPHS [0:7] = '{
        8'h2E, 8'h3A, 8'h2D, 8'h3D, 8'h2B, 8'h2A, 8'h23, 8'h40
    };
    localparam int RAMP_TOP      = 8;
    localparam int SETTLE_CYCLES = 1100;   // a clear walks all 1024 cells
    localparam int HOLD_CYCLES   = 400;    // long receiver hold-off
    localparam int QUIET_LIMIT   = 20000;  // cycles with work pending, no handshake
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        logic [1:0]        cmd;
        logic signed [7:0] x;
        logic signed [7:0] y;
        logic [7:0]        level;
        logic              use_level;
        bit                drain;      // hold this item until all chars are back
    } cmd_item_t;

    typedef struct {
        logic [7:0] code;
        logic       is_last;
    } char_item_t;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [1:0]        command = CMD_PLOT;
    logic signed [7:0] x_coord = '0;
    logic signed [7:0] y_coord = '0;
    logic [7:0]        point_intensity = '0;
    logic              intensity_sel = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [7:0]        char_code;
    logic              row_last;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = CFG_FRAME_WIDTH;
    logic [7:0]        cfg_data = '0;

    char_cell_point_framebuffer_top DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .x_coord         (x_coord),
        .y_coord         (y_coord),
        .point_intensity (point_intensity),
        .intensity_sel   (intensity_sel),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .char_code       (char_code),
        .row_last        (row_last),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Mirror of the block: cell store, geometry and the full-block code
    // ------------------------------------------------------------------------
    logic [7:0] cell_model [0:STORE_CELLS-1];
    int         fb_width  = 32;
    int         fb_height = 32;
    logic [7:0] full_code = 8'd219;

    cmd_item_t  cmd_q[$];       // items waiting for the driver
    char_item_t due_chars[$];   // characters the block still owes us

    int items_queued   = 0;
    int items_accepted = 0;
    int plots_seen     = 0;
    int emits_seen     = 0;
    int rows_out       = 0;
    int clears_seen    = 0;
    int unused_seen    = 0;
    int chars_checked  = 0;
    int fault_count    = 0;
    int settings_run   = 1;     // reset values count as the first setting

    // knobs driven by the sequencer
    bit in_gaps_on  = 1'b1;
    bit out_gaps_on = 1'b1;
    bit hold_req    = 1'b0;
    bit settling    = 1'b0;

    function automatic int clamp_dim(input int v, input int lim);
        return (v > lim) ? lim : v;
    endfunction

    // glyph for one cell: zero is blank, otherwise level = v*9/255 capped at 8
    function automatic logic [7:0] glyph_of(input logic [7:0] v);
        int shade_idx;
        shade_idx = (int'(v) * RAMP_STEPS) / int'(FULL_LEVEL);
        if (v == 8'd0)
            return SPACE_CODE;
        if (shade_idx >= RAMP_TOP)
            return full_code;
        return GLYPHS[shade_idx];
    endfunction

    // apply one accepted command to the mirror and queue the chars it owes
    function automatic void render_command(input cmd_item_t it);
        int         w;
        int         h;
        int         xs;
        int         ys;
        logic [7:0] v;
        char_item_t ch;
        w  = clamp_dim(fb_width, MAX_WIDTH);
        h  = clamp_dim(fb_height, MAX_HEIGHT);
        xs = int'(it.x);
        ys = int'(it.y);
        case (it.cmd)
            CMD_PLOT:
            begin
                plots_seen++;
                v = it.use_level ? it.level : FULL_LEVEL;
                // anything off the active area is dropped
                if (xs >= 0 && ys >= 0 && xs < w && ys < h)
                    cell_model[xs + ys * w] = v;
            end
            CMD_EMIT:
            begin
                emits_seen++;
                if (ys >= 0 && ys < h)
                begin
                    for (int c = 0; c < w; c++)
                    begin
                        ch.code    = glyph_of(cell_model[c + ys * w]);
                        ch.is_last = 1'b0;
                        due_chars.push_back(ch);
                    end
                    ch.code    = NEWLINE_CODE;
                    ch.is_last = 1'b1;
                    due_chars.push_back(ch);
                    rows_out++;
                end
            end
            CMD_CLEAR:
            begin
                clears_seen++;
                foreach (cell_model[i])
                    cell_model[i] = 8'd0;
            end
            default:
                unused_seen++;
        endcase
    endfunction

    function automatic void queue_cmd(input logic [1:0] cmd, input int x, input int y,
                                      input int lvl, input bit use_lvl,
                                      input bit drain = 1'b0);
        cmd_item_t it;
        it.cmd       = cmd;
        it.x         = 8'(x);
        it.y         = 8'(y);
        it.level     = 8'(lvl);
        it.use_level = use_lvl;
        it.drain     = drain;
        cmd_q.push_back(it);
        items_queued++;
    endfunction

    // Random commands shaped by the geometry now in force: mostly in-area
    // plots and valid row emits, a few clears, plus unused codes and
    // coordinates anywhere in the signed range.
    task automatic random_cmds(input int n);
        int        w;
        int        h;
        int        r;
        int        x;
        int        y;
        logic [1:0] cmd;
        w = clamp_dim(fb_width, MAX_WIDTH);
        h = clamp_dim(fb_height, MAX_HEIGHT);
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            x = $urandom_range(0, 255);
            y = $urandom_range(0, 255);
            if (r < 50 && w > 0 && h > 0)
            begin
                cmd = CMD_PLOT;
                x   = $urandom_range(0, w - 1);
                y   = $urandom_range(0, h - 1);
            end
            else if (r < 78 && h > 0)
            begin
                cmd = CMD_EMIT;
                y   = $urandom_range(0, h - 1);
            end
            else if (r < 81)
                cmd = CMD_CLEAR;
            else if (r < 86)
                cmd = CMD_UNUSED;
            else
                cmd = $urandom_range(0, 1) ? CMD_EMIT : CMD_PLOT;
            queue_cmd(cmd, x, y, $urandom_range(0, 255), $urandom_range(0, 3) != 0,
                      $urandom_range(0, 19) == 0);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents queued items, holds a stalled item, draws a gap per item
    // ------------------------------------------------------------------------
    cmd_item_t cur_item;
    int        in_gap_left = 0;
    bit        offer;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid        <= 1'b0;
            command         <= CMD_PLOT;
            x_coord         <= '0;
            y_coord         <= '0;
            point_intensity <= '0;
            intensity_sel   <= 1'b0;
            in_gap_left     = 0;
        end
        else
        begin
            offer = in_valid;
            if (in_valid && !in_stall)
            begin
                render_command(cur_item);
                items_accepted++;
                in_gap_left = in_gaps_on ? $urandom_range(0, 16) : 0;
                offer       = 1'b0;
            end
            if (!offer)
            begin
                if (in_gap_left > 0)
                    in_gap_left--;
                else if (cmd_q.size() > 0 && (!cmd_q[0].drain || due_chars.size() == 0))
                begin
                    cur_item        = cmd_q.pop_front();
                    command         <= cur_item.cmd;
                    x_coord         <= cur_item.x;
                    y_coord         <= cur_item.y;
                    point_intensity <= cur_item.level;
                    intensity_sel   <= cur_item.use_level;
                    offer           = 1'b1;
                end
            end
            in_valid <= offer;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: stalls at random (or for one long hold-off), checks each char
    // ------------------------------------------------------------------------
    char_item_t want;
    int         out_gap_left = 0;
    int         hold_left    = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall    <= 1'b0;
            out_gap_left = 0;
            hold_left    = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                chars_checked++;
                if (due_chars.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("[%0t] unexpected char: code 0x%02h last %0b",
                                 $time, char_code, row_last);
                end
                else
                begin
                    want = due_chars.pop_front();
                    if (char_code !== want.code || row_last !== want.is_last)
                    begin
                        fault_count++;
                        if (fault_count <= MAX_REPORTS)
                            $display("[%0t] code/last exp 0x%02h/%0b got 0x%02h/%0b",
                                     $time, want.code, want.is_last, char_code, row_last);
                    end
                end
                out_gap_left = out_gaps_on ? $urandom_range(0, 16) : 0;
            end
            // a requested hold-off takes priority over the per-item gaps
            if (hold_req && hold_left == 0)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (out_gap_left > 0)
            begin
                out_gap_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: only counts while work is outstanding and nothing moves
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || settling || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)
            || !(items_accepted != items_queued || due_chars.size() != 0 || cfg_valid))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("[%0t] no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------------

    // wait for every item and char, then let a trailing clear finish
    task automatic settle_block();
        while (items_accepted != items_queued || due_chars.size() != 0)
            @(posedge clk);
        settling = 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);
        settling = 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        // registers keep only their own width; unknown indexes do nothing
        case (idx)
            CFG_FRAME_WIDTH:  fb_width  = int'(data[DIM_W-1:0]);
            CFG_FRAME_HEIGHT: fb_height = int'(data[DIM_W-1:0]);
            CFG_FULL_CODE:    full_code = data;
            default:          ;
        endcase
    endtask

    task automatic set_geometry(input int w, input int h, input int code);
        write_reg(CFG_FRAME_WIDTH, 8'(w));
        write_reg(CFG_FRAME_HEIGHT, 8'(h));
        write_reg(CFG_FULL_CODE, 8'(code));
        settings_run++;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        foreach (cell_model[i])
            cell_model[i] = 8'd0;

        // Directed, reset geometry 32x32: ramp thresholds along row 0,
        // default full intensity, overwrite to blank, edges and off-area
        // points, rows outside the frame, the unused code, and a clear.
        queue_cmd(CMD_PLOT, 0, 0, 1, 1);        // lowest nonzero
        queue_cmd(CMD_PLOT, 1, 0, 28, 1);       // last value of the first shade
        queue_cmd(CMD_PLOT, 2, 0, 29, 1);       // first value of the second
        queue_cmd(CMD_PLOT, 3, 0, 226, 1);      // top of '@'
        queue_cmd(CMD_PLOT, 4, 0, 227, 1);      // first full-block value
        queue_cmd(CMD_PLOT, 5, 0, 0, 0);        // flag clear: full intensity
        queue_cmd(CMD_PLOT, 6, 0, 255, 1);
        queue_cmd(CMD_PLOT, 31, 0, 128, 1);
        queue_cmd(CMD_PLOT, 31, 31, 100, 1);
        queue_cmd(CMD_PLOT, -1, 0, 255, 1);     // off the left edge
        queue_cmd(CMD_PLOT, 32, 0, 255, 1);     // just past the width
        queue_cmd(CMD_PLOT, 0, 32, 255, 0);     // just past the height
        queue_cmd(CMD_PLOT, -128, -128, 255, 1);
        queue_cmd(CMD_PLOT, 127, 127, 255, 1);
        queue_cmd(CMD_EMIT, 0, 0, 0, 0);
        queue_cmd(CMD_PLOT, 31, 0, 0, 1);       // back to blank
        queue_cmd(CMD_EMIT, 127, 0, 0, 0);
        queue_cmd(CMD_EMIT, 0, 31, 0, 0);       // bottom row
        queue_cmd(CMD_EMIT, 0, -1, 0, 0);       // negative row
        queue_cmd(CMD_EMIT, 0, 32, 0, 0);       // row past the height
        queue_cmd(CMD_EMIT, 0, -128, 0, 0);
        queue_cmd(CMD_EMIT, 0, 127, 0, 0);
        queue_cmd(CMD_UNUSED, 5, 5, 255, 1);
        queue_cmd(CMD_CLEAR, 0, 0, 0, 0, 1'b1); // sender waits for the rows first
        queue_cmd(CMD_EMIT, 0, 0, 0, 0);        // all blank after the clear

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        settle_block();

        // zero width: plots dropped, a valid row is just the newline
        set_geometry(0, 5, 0);
        queue_cmd(CMD_PLOT, 0, 0, 200, 1);
        queue_cmd(CMD_EMIT, 0, 0, 0, 0);
        queue_cmd(CMD_EMIT, 0, 4, 0, 0);
        queue_cmd(CMD_EMIT, 0, 5, 0, 0);
        queue_cmd(CMD_EMIT, 0, -1, 0, 0);
        settle_block();

        // all-ones width (masked, clamped), zero height: nothing comes out;
        // also poke the index past the register list
        set_geometry(8'hFF, 0, 255);
        write_reg(CFG_NONE, 8'h5A);
        queue_cmd(CMD_PLOT, 1, 1, 200, 1);
        queue_cmd(CMD_EMIT, 0, 0, 0, 0);
        queue_cmd(CMD_EMIT, 0, 31, 0, 0);
        settle_block();

        // oversized width and height clamp to the store size
        set_geometry(40, 63, 255);
        queue_cmd(CMD_PLOT, 31, 31, 240, 1);
        queue_cmd(CMD_PLOT, 32, 0, 240, 1);
        queue_cmd(CMD_EMIT, 0, 31, 0, 0);
        queue_cmd(CMD_EMIT, 0, 32, 0, 0);
        settle_block();

        // random phases, each under a fresh geometry; the store is never
        // cleared between them, so old contents read back in a new layout
        for (int p = 0; p < 6; p++)
        begin
            if (p == 2)
                set_geometry(32, 32, $urandom_range(0, 255));
            else
                set_geometry($urandom_range(0, 4) == 0 ? $urandom_range(33, 63)
                                                       : $urandom_range(1, 32),
                             $urandom_range(0, 4) == 0 ? $urandom_range(33, 63)
                                                       : $urandom_range(1, 32),
                             $urandom_range(0, 255));
            in_gaps_on  = (p != 2 && p != 4);
            out_gaps_on = (p != 2);
            if (p == 2)
            begin
                // receiver goes dark while full-width rows keep coming in
                hold_req = 1'b1;
                repeat (6)
                    queue_cmd(CMD_EMIT, 0, $urandom_range(0, 31), 0, 0);
            end
            random_cmds(14);
            settle_block();
        end

        $display("Covered %0d items: %0d plots, %0d emits (%0d rows), %0d clears, %0d unused",
                 items_accepted, plots_seen, emits_seen, rows_out, clears_seen, unused_seen);
        $display("Checked %0d chars over %0d register settings, %0d faults",
                 chars_checked, settings_run, fault_count);
        if (fault_count == 0 && due_chars.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ccpf_pkg.sv
sv/ccpf_front.sv
sv/ccpf_queue.sv
sv/ccpf_back.sv
sv/char_cell_point_framebuffer_top.sv
tb/tb_top.sv
